[design/jet_pkg.sv]
// Shared types and constants for the Julia escape-time block.
package jet_pkg;

    localparam int POINT_W     = 32;   // z coordinate width
    localparam int PROD_W      = 64;   // full product width
    localparam int C_W         = 30;   // Julia constant width
    localparam int CNT_W       = 16;   // escape count / iteration limit width
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 30;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_C_REAL   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_C_IMAG   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITER = 2'd2;

    // reset values (about -0.650492 and -0.478235 at 27 fraction bits)
    localparam logic signed [C_W-1:0] C_REAL_RESET   = -30'sd87307558;
    localparam logic signed [C_W-1:0] C_IMAG_RESET   = -30'sd64187615;
    localparam logic [CNT_W-1:0]      MAX_ITER_RESET = 16'd255;

    typedef struct packed {
        logic load;     // take a new start point, clear count
        logic mul;      // register the three products
        logic step;     // commit z*z + c, bump count
        logic capture;  // move count into the result register
    } t_dp_cmd;

    typedef struct packed {
        logic count_done;  // count reached the limit
        logic escaped;     // x*x + y*y > 4
    } t_dp_sts;

endpackage

[design/julia_escape_time.sv]
// Top level of the Julia set escape-time counter.
//
// Usage:
//  - Slave stream: one request per point; tdata carries point_real and
//    point_imag, both signed with FRACTION_BITS fraction bits.
//  - Master stream: one request per point with the escape count.
//  - Config channel: index 0 = c_real, 1 = c_imag (writes outside [-2, 2]
//    are dropped), 2 = max_iterations; other indexes are ignored. Write only
//    while no point is in flight. Always ready.
//  - Each iteration has a multiply state that registers the three 32x32
//    products and a check state for the |z|^2 > 4 test and z*z + c update.
//    One point is in flight at a time; the next is taken once the result
//    has moved to the output register and the block is back in idle.
//  - The result sits in an output register: a new point is accepted while
//    the previous result waits. If the receiver stalls, the next point
//    finishes and holds in its final state until the register frees up.
//  - Synchronous active-low reset: block idle, output empty, c back to
//    about -0.650492 - 0.478235i and the limit to 255.
module julia_escape_time #(
    parameter int FRACTION_BITS = 27,
    parameter int COUNT_WIDTH   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [63:0]                      i_s_tdata,   // [31:0] point_real, [63:32] point_imag
    // master stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [15:0]                      o_m_tdata,   // [15:0] escape_count
    // config write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [jet_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [jet_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic signed [jet_pkg::C_W-1:0] w_c_real;
    logic signed [jet_pkg::C_W-1:0] w_c_imag;
    logic [jet_pkg::CNT_W-1:0]      w_limit;
    jet_pkg::t_dp_cmd               w_cmd;
    jet_pkg::t_dp_sts               w_sts;

    jet_cfg #(
        .FRACTION_BITS (FRACTION_BITS),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_c_real    (w_c_real),
        .o_c_imag    (w_c_imag),
        .o_limit     (w_limit)
    );

    jet_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    jet_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_point_real   ($signed(i_s_tdata[31:0])),
        .i_point_imag   ($signed(i_s_tdata[63:32])),
        .i_c_real       (w_c_real),
        .i_c_imag       (w_c_imag),
        .i_limit        (w_limit),
        .o_escape_count (o_m_tdata)
    );

endmodule

[design/jet_cfg.sv]
// Configuration registers: Julia constant and iteration limit.
module jet_cfg #(
    parameter int FRACTION_BITS = 27,
    parameter int COUNT_WIDTH   = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [jet_pkg::CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [jet_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    output logic signed [jet_pkg::C_W-1:0]         o_c_real,
    output logic signed [jet_pkg::C_W-1:0]         o_c_imag,
    output logic [jet_pkg::CNT_W-1:0]              o_limit
);

    localparam logic signed [63:0] C_BOUND = 64'sd2 <<< FRACTION_BITS;
    localparam logic [63:0] CNT_MAX =
        (COUNT_WIDTH >= 32) ? 64'hFFFF_FFFF : ((64'd1 << COUNT_WIDTH) - 64'd1);

    logic signed [jet_pkg::C_W-1:0] r_c_real;
    logic signed [jet_pkg::C_W-1:0] r_c_imag;
    logic [jet_pkg::CNT_W-1:0]      r_max_iter;
    logic signed [63:0]             w_value;
    logic                           w_in_range;

    assign o_cfg_ready = 1'b1;
    assign w_value     = 64'($signed(i_cfg_data));
    assign w_in_range  = (w_value >= -C_BOUND) && (w_value <= C_BOUND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_real   <= jet_pkg::C_REAL_RESET;
            r_c_imag   <= jet_pkg::C_IMAG_RESET;
            r_max_iter <= jet_pkg::MAX_ITER_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                jet_pkg::REG_C_REAL: begin
                    if (w_in_range) r_c_real <= $signed(i_cfg_data);
                end
                jet_pkg::REG_C_IMAG: begin
                    if (w_in_range) r_c_imag <= $signed(i_cfg_data);
                end
                jet_pkg::REG_MAX_ITER: begin
                    r_max_iter <= i_cfg_data[jet_pkg::CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_c_real = r_c_real;
    assign o_c_imag = r_c_imag;
    // limit clamps at the largest value a COUNT_WIDTH-bit counter can hold
    assign o_limit  = (64'(r_max_iter) > CNT_MAX) ? CNT_MAX[jet_pkg::CNT_W-1:0] : r_max_iter;

endmodule

[design/jet_dp.sv]
// Datapath: z registers, product registers, escape test and update.
module jet_dp #(
    parameter int FRACTION_BITS = 27
) (
    input  logic                                 i_clk,
    input  jet_pkg::t_dp_cmd                     i_cmd,
    output jet_pkg::t_dp_sts                     o_sts,
    input  logic signed [jet_pkg::POINT_W-1:0]   i_point_real,
    input  logic signed [jet_pkg::POINT_W-1:0]   i_point_imag,
    input  logic signed [jet_pkg::C_W-1:0]       i_c_real,
    input  logic signed [jet_pkg::C_W-1:0]       i_c_imag,
    input  logic [jet_pkg::CNT_W-1:0]            i_limit,
    output logic [jet_pkg::CNT_W-1:0]            o_escape_count
);

    localparam int PW = jet_pkg::PROD_W;
    // 4 << 2*FB no longer fits the unsigned 64-bit sum: nothing escapes
    localparam bit WIDE = (2 * FRACTION_BITS + 2) >= 64;
    localparam logic [PW-1:0] THRESH = WIDE ? '1 : (64'd4 << (2 * FRACTION_BITS));
    localparam logic signed [PW-1:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [PW-1:0] S32_MIN = -64'sd2147483648;

    logic signed [jet_pkg::POINT_W-1:0] r_x, r_y;
    logic signed [PW-1:0]               r_pxx, r_pyy, r_pxy;
    logic [jet_pkg::CNT_W-1:0]          r_count;
    logic [jet_pkg::CNT_W-1:0]          r_result;

    logic [PW-1:0]        w_r2;
    logic signed [PW-1:0] w_nx, w_ny;
    logic signed [jet_pkg::POINT_W-1:0] n_x, n_y;

    // squares are non-negative, so the unsigned sum is |z|^2 exactly
    assign w_r2 = r_pxx + r_pyy;
    assign w_nx = (r_pxx >>> FRACTION_BITS) - (r_pyy >>> FRACTION_BITS) + PW'(i_c_real);
    assign w_ny = (r_pxy >>> (FRACTION_BITS - 1)) + PW'(i_c_imag);

    always_comb begin
        if (w_nx > S32_MAX)      n_x = S32_MAX[jet_pkg::POINT_W-1:0];
        else if (w_nx < S32_MIN) n_x = S32_MIN[jet_pkg::POINT_W-1:0];
        else                     n_x = w_nx[jet_pkg::POINT_W-1:0];
        if (w_ny > S32_MAX)      n_y = S32_MAX[jet_pkg::POINT_W-1:0];
        else if (w_ny < S32_MIN) n_y = S32_MIN[jet_pkg::POINT_W-1:0];
        else                     n_y = w_ny[jet_pkg::POINT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x     <= i_point_real;
            r_y     <= i_point_imag;
            r_count <= '0;
        end else if (i_cmd.step) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_count <= r_count + 1'b1;
        end
        if (i_cmd.mul) begin
            r_pxx <= PW'(r_x) * PW'(r_x);
            r_pyy <= PW'(r_y) * PW'(r_y);
            r_pxy <= PW'(r_x) * PW'(r_y);
        end
        if (i_cmd.capture) begin
            r_result <= r_count;
        end
    end

    assign o_sts.count_done = (r_count >= i_limit);
    assign o_sts.escaped    = !WIDE && (w_r2 > THRESH);
    assign o_escape_count   = r_result;

endmodule

[design/jet_ctrl.sv]
// Controller: sequences load, multiply, test/update and result handoff.
module jet_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output jet_pkg::t_dp_cmd o_cmd,
    input  jet_pkg::t_dp_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_CHK,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_s_tready, n_s_tready;
    logic   r_m_tvalid, n_m_tvalid;

    always_comb begin
        n_state      = r_state;
        n_s_tready   = r_s_tready;
        n_m_tvalid   = r_m_tvalid && !i_m_tready;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && r_s_tready) begin
                    o_cmd.load = 1'b1;
                    n_s_tready = 1'b0;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                if (i_sts.count_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.escaped) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_FIN: begin
                if (!r_m_tvalid || i_m_tready) begin
                    o_cmd.capture = 1'b1;
                    n_m_tvalid    = 1'b1;
                    n_s_tready    = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_s_tready <= 1'b1;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s_tready <= n_s_tready;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    assign o_s_tready = r_s_tready;
    assign o_m_tvalid = r_m_tvalid;

endmodule

[test/julia_escape_time_checker.sv]
// Watches the point, result and register channels of the escape-time block and checks every result.
module julia_escape_time_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [63:0]                     i_s_tdata,    // [31:0] point_real, [63:32] point_imag
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [15:0]                     i_m_tdata,    // [15:0] escape_count
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [jet_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [jet_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_pending,
    output int                              o_failures,
    output int                              o_matched
);
    import jet_pkg::*;

    localparam int              FRAC        = 27;
    localparam longint          C_BOUND     = 64'sd2 << FRAC;
    localparam longint unsigned RADIUS_SQ   = 64'd4 << (2 * FRAC);   // |z|^2 = 4
    localparam longint          POINT_MAX   = 64'sd2147483647;
    localparam longint          POINT_MIN   = -64'sd2147483648;

    logic signed [C_W-1:0] julia_c_re;
    logic signed [C_W-1:0] julia_c_im;
    logic [CNT_W-1:0]      iter_limit;
    logic [CNT_W-1:0]      counts_due[$];
    int                    fail_tally;
    int                    match_tally;

    function automatic longint clamp_point(longint v);
        if (v > POINT_MAX) return POINT_MAX;
        if (v < POINT_MIN) return POINT_MIN;
        return v;
    endfunction

    function automatic bit c_in_range(logic signed [C_W-1:0] v);
        return (longint'(v) >= -C_BOUND) && (longint'(v) <= C_BOUND);
    endfunction

    // z = z*z + c until |z| > 2 or the limit; products floor back to FRAC bits
    function automatic logic [CNT_W-1:0] escape_count(logic signed [31:0] re0,
                                                       logic signed [31:0] im0);
        longint          x;
        longint          y;
        longint          xx;
        longint          yy;
        longint          xy2;
        longint unsigned mx;
        longint unsigned my;
        int unsigned     n;
        bit              escaped;
        x = re0;
        y = im0;
        n = 0;
        escaped = 1'b0;
        while (n < iter_limit && !escaped) begin
            mx = (x < 0) ? -x : x;
            my = (y < 0) ? -y : y;
            if (mx * mx + my * my > RADIUS_SQ) begin
                escaped = 1'b1;
            end else begin
                xx  = (x * x) >>> FRAC;
                yy  = (y * y) >>> FRAC;
                xy2 = (x * y) >>> (FRAC - 1);
                x   = clamp_point(xx - yy + longint'(julia_c_re));
                y   = clamp_point(xy2 + longint'(julia_c_im));
                n++;
            end
        end
        return n[CNT_W-1:0];
    endfunction

    always @(posedge i_clk) begin : watch
        logic [CNT_W-1:0] want;
        if (!i_rst_n) begin
            julia_c_re = C_REAL_RESET;
            julia_c_im = C_IMAG_RESET;
            iter_limit = MAX_ITER_RESET;
            counts_due.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_C_REAL: begin
                        if (c_in_range($signed(i_cfg_data))) julia_c_re = $signed(i_cfg_data);
                    end
                    REG_C_IMAG: begin
                        if (c_in_range($signed(i_cfg_data))) julia_c_im = $signed(i_cfg_data);
                    end
                    REG_MAX_ITER: begin
                        iter_limit = i_cfg_data[CNT_W-1:0];
                    end
                    default: ;
                endcase
            end
            // results first, so a stray one never meets this edge's new point
            if (i_m_tvalid && i_m_tready) begin
                if (counts_due.size() == 0) begin
                    $error("escape_count: result with no point outstanding, actual %0d",
                           i_m_tdata);
                    fail_tally++;
                end else begin
                    want = counts_due.pop_front();
                    if (i_m_tdata !== want) begin
                        $error("escape_count mismatch: expected %0d, actual %0d",
                               want, i_m_tdata);
                        fail_tally++;
                    end else begin
                        match_tally++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                counts_due.push_back(escape_count(i_s_tdata[31:0], i_s_tdata[63:32]));
            o_pending <= counts_due.size();
        end
        o_failures <= fail_tally;
        o_matched  <= match_tally;
    end

endmodule

[test/julia_escape_time_test.sv]
// Stimulus and verdict for the Julia escape-time block; checking sits in the checker module.
module julia_escape_time_test;
    import jet_pkg::*;

    localparam int     RESET_CYCLES   = 11;
    localparam longint CYCLE_LIMIT    = 64'd3_000_000;   // several times the slowest run
    localparam int     PHASE_POINTS   = 115;
    localparam int     DEEP_POINTS    = 25;              // points per phase at the full 255 limit
    localparam int     END_WAIT_CAP   = 2000;

    // spare index: writes there must leave every register alone
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    // plane coordinates with 27 fraction bits
    localparam logic signed [31:0] Q_ONE     = 32'sd134217728;
    localparam logic signed [31:0] Q_TWO     = 32'sd268435456;
    localparam logic signed [31:0] POINT_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] POINT_MIN = 32'sh80000000;

    typedef enum int {
        PRESSURE_NONE,
        PRESSURE_SENDER,
        PRESSURE_RECEIVER,
        PRESSURE_BOTH
    } pressure_e;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [63:0]            i_s_tdata;     // [31:0] point_real, [63:32] point_imag
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [15:0]            o_m_tdata;     // [15:0] escape_count
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int     pending;
    int     failures;
    int     matched;
    longint cycle_count = 0;
    int     sender_idle_pct = 0;
    int     receiver_stall_pct = 0;
    int     current_limit = MAX_ITER_RESET;
    int     points_sent = 0;
    int     reg_writes = 0;

    julia_escape_time DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    julia_escape_time_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_failures  (failures),
        .o_matched   (matched)
    );

    always #4 i_clk = ~i_clk;

    // hard stop if the block hangs somewhere
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // register write; one dead cycle after each so valid never drops and rises in one step
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        reg_writes++;
        if (idx == REG_MAX_ITER) current_limit = data[CNT_W-1:0];
    endtask

    // limit write with random junk above the 16 used bits
    task automatic write_limit(input logic [CNT_W-1:0] lim);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        data[CNT_W-1:0] = lim;
        write_reg(REG_MAX_ITER, data);
    endtask

    // one point request; valid stays high straight into the next one when no gap is drawn
    task automatic send_point(input logic signed [31:0] re, input logic signed [31:0] im);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {im, re};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        points_sent++;
    endtask

    // block idle: every predicted count has come back
    task automatic drain;
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] plane_coord(int unsigned span);
        return $signed($urandom_range(0, 2 * span) - span);
    endfunction

    // mostly points inside the radius-2 disc where iteration goes deep, some noise
    task automatic send_random_point;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15)
            send_point($urandom, $urandom);
        else if (pick < 50)
            send_point(plane_coord(Q_TWO), plane_coord(Q_TWO));
        else if (pick < 90)
            send_point(plane_coord(Q_ONE), plane_coord(Q_ONE));
        else
            // just on or just past the escape circle along an axis
            send_point($urandom_range(1) ? Q_TWO + $urandom_range(1) : -Q_TWO - $urandom_range(1),
                       plane_coord(4));
    endtask

    // new Julia constant: a raw 30-bit write (often out of range, so dropped),
    // sometimes followed by one that surely lands
    task automatic pick_julia_constant;
        write_reg(REG_C_REAL, CFG_DATA_W'($urandom));
        if ($urandom_range(1)) write_reg(REG_C_REAL, CFG_DATA_W'(plane_coord(Q_ONE)));
        write_reg(REG_C_IMAG, CFG_DATA_W'($urandom));
        if ($urandom_range(1)) write_reg(REG_C_IMAG, CFG_DATA_W'(plane_coord(Q_ONE)));
        if ($urandom_range(3) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    endtask

    initial begin
        int points;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_C_REAL;
        i_cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part, reset constant and limit 255 ----
        send_point(0, 0);
        send_point(Q_TWO, 0);               // exactly on |z| = 2: not escaped yet
        send_point(0, -Q_TWO);
        send_point(-Q_TWO, 0);
        send_point(Q_TWO + 1, 0);           // just outside: count 0
        send_point(0, -Q_TWO - 1);
        send_point(POINT_MAX, POINT_MAX);   // extremes of both fields
        send_point(POINT_MIN, POINT_MIN);
        send_point(POINT_MIN, POINT_MAX);
        send_point(POINT_MAX, POINT_MIN);
        send_point(1, -1);
        send_point(Q_ONE, Q_ONE);
        drain();

        // zero limit: nothing iterates
        write_limit('0);
        send_point(0, 0);
        send_point(-1, -1);
        drain();

        // c = 0 keeps the origin fixed, so the count runs to the full 16-bit limit
        write_reg(REG_C_REAL, '0);
        write_reg(REG_C_IMAG, '0);
        write_limit(16'hFFFF);
        send_point(0, 0);
        send_point(Q_TWO, 0);
        drain();

        // c at +2 - 2i, then out-of-range writes on each register that must be dropped
        write_reg(REG_C_REAL, CFG_DATA_W'(Q_TWO));
        write_reg(REG_C_IMAG, CFG_DATA_W'(-Q_TWO));
        write_reg(REG_C_REAL, CFG_DATA_W'(Q_TWO + 1));
        write_reg(REG_C_IMAG, CFG_DATA_W'(-Q_TWO - 1));
        write_reg(REG_C_REAL, 30'h1FFFFFFF);
        write_reg(REG_C_IMAG, 30'h20000000);
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        write_limit(CNT_W'(3));
        send_point(0, 0);
        send_point(Q_ONE, -Q_ONE);
        drain();

        // c at -2 + 2i
        write_reg(REG_C_REAL, CFG_DATA_W'(-Q_TWO));
        write_reg(REG_C_IMAG, CFG_DATA_W'(Q_TWO));
        write_limit(CNT_W'(1));
        send_point(0, 0);
        send_point(Q_ONE, 0);
        drain();

        // ---- random part: four back-pressure modes, five settings each ----
        for (int mode = PRESSURE_NONE; mode <= PRESSURE_BOTH; mode++) begin
            case (pressure_e'(mode))
                PRESSURE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                PRESSURE_SENDER:   begin sender_idle_pct = 52; receiver_stall_pct = 0;  end
                PRESSURE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 52; end
                default:           begin sender_idle_pct = 8;  receiver_stall_pct = 8;  end
            endcase
            for (int setting = 0; setting < 5; setting++) begin
                pick_julia_constant();
                // limits stay small to keep the run short; one deep setting per mode
                if (setting == 0) begin
                    write_limit(MAX_ITER_RESET);
                    points = DEEP_POINTS;
                end else if (setting == 1) begin
                    write_limit(CNT_W'($urandom_range(0, 3)));
                    points = PHASE_POINTS;
                end else begin
                    write_limit(CNT_W'($urandom_range(4, 48)));
                    points = PHASE_POINTS;
                end
                for (int n = 0; n < points; n++) send_random_point();
                drain();
            end
        end

        // nothing left in flight; keep watching for a stray result before the verdict
        repeat ((2 * current_limit + 8 < END_WAIT_CAP) ? 2 * current_limit + 8 : END_WAIT_CAP)
            @(posedge i_clk);

        $display("Ran %0d points (%0d counts matched) through %0d register writes,",
                 points_sent, matched, reg_writes);
        $display("covering c and limit extremes, dropped writes, idle and stall mixes.");
        if (failures == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
design/jet_pkg.sv
design/jet_cfg.sv
design/jet_dp.sv
design/jet_ctrl.sv
design/julia_escape_time.sv
test/julia_escape_time_checker.sv
test/julia_escape_time_test.sv
